// ===== rtl/core/huffman_code_builder_encoder_core_macros.svh =====
// assertion macros for the huffman code builder and encoder core
`ifndef HUFFMAN_CODE_BUILDER_ENCODER_CORE_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_ENCODER_CORE_MACROS_SVH
`ifndef SYNTH
`define HCBE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hcbe assertion failed");
`define HCBE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hcbe assertion failed");
`else
`define HCBE_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define HCBE_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/hcbe_pkg.sv =====
// types and constants shared by the huffman code builder and encoder
`timescale 1ns / 1ps
package hcbe_pkg;
	localparam int WEIGHT_W = 41;
	localparam int ID_W     = 9;
	localparam int CODE_W   = 63;
	localparam int LEN_W    = 6;
	localparam int SYM_W    = 8;
	localparam int REQ_W    = 2;

	localparam logic [REQ_W-1:0] REQ_COUNT  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_BUILD  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd2;
	localparam logic [REQ_W-1:0] REQ_END    = 2'd3;

	localparam logic [SYM_W-1:0] END_SYMBOL = 8'd4;
	localparam logic [LEN_W-1:0] LEN_MAX    = 6'd63;

	localparam logic [1:0] CH_HOLD = 2'd0;
	localparam logic [1:0] CH_CLR  = 2'd1;
	localparam logic [1:0] CH_INS  = 2'd2;
	localparam logic [1:0] CH_MRG  = 2'd3;

	typedef struct packed {
		logic                vld;
		logic [WEIGHT_W-1:0] weight;
		logic [ID_W-1:0]     id;
	} node_t;

	typedef struct packed {
		node_t node;
		logic  lt;
	} link_t;

	typedef struct packed {
		logic [1:0] op;
		node_t      nn;
	} chain_cmd_t;

	localparam link_t LINK_NONE = '0;
	localparam link_t LINK_HEAD = '{node: '0, lt: 1'b1};
endpackage

// ===== rtl/core/hcbe_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
interface hcbe_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] byte_value;
	modport source(output valid, output req_type, output byte_value, input ready);
	modport sink(input valid, input req_type, input byte_value, output ready);
endinterface

interface hcbe_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  symbol;
	logic [5:0]  code_length;
	logic [62:0] code_bits;
	modport source(output valid, output symbol, output code_length, output code_bits,
		input ready);
	modport sink(input valid, input symbol, input code_length, input code_bits,
		output ready);
endinterface

// ===== rtl/core/hcbe_cell.sv =====
// one cell of the sorted node chain
`timescale 1ns / 1ps
module hcbe_cell import hcbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  chain_cmd_t cmd,
	input  logic       head,
	input  link_t      prev1,
	input  link_t      next1,
	input  link_t      next2,
	output link_t      self
);
	logic                vld_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [ID_W-1:0]     id_q;
	node_t               node_d;

	assign self.node = '{vld: vld_q, weight: weight_q, id: id_q};
	// new node has the highest sequence number, so a tie keeps the old node ahead
	assign self.lt = vld_q && (weight_q <= cmd.nn.weight);

	always_comb begin
		node_d = self.node;
		case (cmd.op)
			CH_CLR: begin
				node_d.vld = 1'b0;
			end
			CH_INS: begin
				if (!self.lt) begin
					node_d = prev1.lt ? cmd.nn : prev1.node;
				end
			end
			CH_MRG: begin
				// two lowest leave the head, everything moves up by two around the new node
				if (next2.lt) begin
					node_d = next2.node;
				end else if (head || next1.lt) begin
					node_d = cmd.nn;
				end else begin
					node_d = next1.node;
				end
			end
			default: begin
				node_d = self.node;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= node_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		weight_q <= node_d.weight;
		id_q     <= node_d.id;
	end
endmodule

// ===== rtl/core/huffman_code_builder_encoder_core.sv =====
// static huffman code builder and encoder over a chain of sorted node cells
// count word: histogram read, then saturating write-back; encode or end word: node memory read,
// result registered once the output is free; build word: histogram load into the chain,
// SYMBOLS-1 merges at one per cycle, code walk: read, left and right write per internal node
// one word in flight; reset clears control state, the chain and the histogram valid bits
`timescale 1ns / 1ps
`include "huffman_code_builder_encoder_core_macros.svh"
module huffman_code_builder_encoder_core import hcbe_pkg::*; #(
	parameter int SYMBOLS     = 256,
	parameter int COUNT_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	hcbe_in_if.sink    req,
	hcbe_out_if.source rsp
);
	localparam int NODES   = 2 * SYMBOLS - 1;
	localparam int SYM_AW  = $clog2(SYMBOLS);
	localparam int NODE_AW = $clog2(NODES);
	localparam int CH_AW   = (SYMBOLS > 2) ? $clog2(SYMBOLS - 1) : 1;
	localparam int LDC_W   = SYM_AW + 1;
	localparam int ENT_W   = LEN_W + CODE_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CNT  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_MRG  = 3'd3;
	localparam logic [2:0] ST_WRD  = 3'd4;
	localparam logic [2:0] ST_WL   = 3'd5;
	localparam logic [2:0] ST_WR   = 3'd6;
	localparam logic [2:0] ST_ENC  = 3'd7;

	logic [2:0] state_q, state_d;

	// histogram
	logic [COUNT_WIDTH-1:0] cnt_mem [SYMBOLS];
	logic [SYMBOLS-1:0]     cnt_vld_q;
	logic [SYM_AW-1:0]      cnt_raddr, cnt_waddr;
	logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata_q, cnt_cur;
	logic                   cnt_we, cnt_rvld_q;

	// per-node code and length, leaves double as the code table
	logic [ENT_W-1:0]   walk_mem [NODES];
	logic [NODE_AW-1:0] walk_raddr, walk_waddr;
	logic [ENT_W-1:0]   walk_wdata, walk_rdata_q;
	logic               walk_we, walk_re;

	logic [2*ID_W-1:0] ch_mem [SYMBOLS-1];
	logic [CH_AW-1:0]  ch_raddr, ch_waddr;
	logic [2*ID_W-1:0] ch_wdata, ch_rdata_q;
	logic              ch_we, ch_re;

	logic [SYM_AW-1:0] byte_q;
	logic [LDC_W-1:0]  ld_idx_q, ld_prev;
	logic [ID_W-1:0]   next_q, walk_n_q, ch_off, walk_off;
	logic [SYM_W-1:0]  enc_sym, enc_sym_q;
	logic              enc_inr, enc_inr_q, byte_inr;
	logic              req_acc, out_load;

	logic              out_valid_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic [LEN_W-1:0]  out_len_q, rlen, nlen;
	logic [CODE_W-1:0] out_code_q, base;
	logic [WEIGHT_W-1:0] sum, ld_w;

	chain_cmd_t chain_cmd;
	link_t      links [SYMBOLS];

	for (genvar i = 0; i < SYMBOLS; i++) begin : g_cell
		link_t prev1, next1, next2;
		if (i == 0) begin : g_head
			assign prev1 = LINK_HEAD;
		end else begin : g_mid
			assign prev1 = links[i-1];
		end
		if (i + 1 < SYMBOLS) begin : g_n1
			assign next1 = links[i+1];
		end else begin : g_e1
			assign next1 = LINK_NONE;
		end
		if (i + 2 < SYMBOLS) begin : g_n2
			assign next2 = links[i+2];
		end else begin : g_e2
			assign next2 = LINK_NONE;
		end
		hcbe_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (chain_cmd),
			.head   (i == 0),
			.prev1  (prev1),
			.next1  (next1),
			.next2  (next2),
			.self   (links[i])
		);
	end

	assign req_acc   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign byte_inr  = {1'b0, req.byte_value} < 9'(SYMBOLS);
	assign enc_sym   = (req.req_type == REQ_END) ? END_SYMBOL : req.byte_value;
	assign enc_inr   = {1'b0, enc_sym} < 9'(SYMBOLS);

	assign cnt_cur  = cnt_rvld_q ? cnt_rdata_q : '0;
	assign ld_w     = (cnt_cur == '0) ? WEIGHT_W'(1) : WEIGHT_W'(cnt_cur);
	assign ld_prev  = ld_idx_q - LDC_W'(1);
	assign sum      = links[0].node.weight + links[1].node.weight;
	assign ch_off   = next_q - ID_W'(SYMBOLS);
	assign walk_off = walk_n_q - ID_W'(SYMBOLS);
	assign rlen     = walk_rdata_q[ENT_W-1:CODE_W];
	assign nlen     = (rlen == LEN_MAX) ? LEN_MAX : rlen + LEN_W'(1);
	assign base     = {walk_rdata_q[CODE_W-2:0], 1'b0};

	always_comb begin
		state_d    = state_q;
		chain_cmd  = '{op: CH_HOLD, nn: '0};
		cnt_raddr  = '0;
		cnt_waddr  = '0;
		cnt_wdata  = '0;
		cnt_we     = 1'b0;
		walk_raddr = '0;
		walk_waddr = '0;
		walk_wdata = '0;
		walk_we    = 1'b0;
		walk_re    = 1'b0;
		ch_raddr   = '0;
		ch_waddr   = '0;
		ch_wdata   = '0;
		ch_we      = 1'b0;
		ch_re      = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					case (req.req_type)
						REQ_COUNT: begin
							if (byte_inr) begin
								cnt_raddr = req.byte_value[SYM_AW-1:0];
								state_d   = ST_CNT;
							end
						end
						REQ_BUILD: begin
							chain_cmd.op = CH_CLR;
							state_d      = ST_LOAD;
						end
						default: begin
							walk_re    = enc_inr;
							walk_raddr = NODE_AW'(enc_sym);
							state_d    = ST_ENC;
						end
					endcase
				end
			end
			ST_CNT: begin
				cnt_we    = (cnt_cur != COUNT_MAX);
				cnt_waddr = byte_q;
				cnt_wdata = cnt_cur + COUNT_WIDTH'(1);
				state_d   = ST_IDLE;
			end
			ST_LOAD: begin
				// read leaf k while inserting leaf k-1
				if (ld_idx_q < LDC_W'(SYMBOLS)) begin
					cnt_raddr = ld_idx_q[SYM_AW-1:0];
				end
				if (ld_idx_q != '0) begin
					chain_cmd.op = CH_INS;
					chain_cmd.nn = '{vld: 1'b1, weight: ld_w, id: ID_W'(ld_prev)};
					cnt_we       = (cnt_cur == '0);
					cnt_waddr    = ld_prev[SYM_AW-1:0];
					cnt_wdata    = COUNT_WIDTH'(1);
				end
				if (ld_idx_q == LDC_W'(SYMBOLS)) begin
					state_d = ST_MRG;
				end
			end
			ST_MRG: begin
				chain_cmd.op = CH_MRG;
				chain_cmd.nn = '{vld: 1'b1, weight: sum, id: next_q};
				ch_we        = 1'b1;
				ch_waddr     = ch_off[CH_AW-1:0];
				ch_wdata     = {links[1].node.id, links[0].node.id};
				if (next_q == ID_W'(NODES - 1)) begin
					// root gets the empty code
					walk_we    = 1'b1;
					walk_waddr = NODE_AW'(NODES - 1);
					walk_wdata = '0;
					state_d    = ST_WRD;
				end
			end
			ST_WRD: begin
				walk_re    = 1'b1;
				walk_raddr = walk_n_q[NODE_AW-1:0];
				ch_re      = 1'b1;
				ch_raddr   = walk_off[CH_AW-1:0];
				state_d    = ST_WL;
			end
			ST_WL: begin
				walk_we    = 1'b1;
				walk_waddr = ch_rdata_q[NODE_AW-1:0];
				walk_wdata = {nlen, base};
				state_d    = ST_WR;
			end
			ST_WR: begin
				walk_we    = 1'b1;
				walk_waddr = ch_rdata_q[ID_W+NODE_AW-1:ID_W];
				walk_wdata = {nlen, base[CODE_W-1:1], 1'b1};
				state_d    = (walk_n_q == ID_W'(SYMBOLS)) ? ST_IDLE : ST_WRD;
			end
			ST_ENC: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rdata_q <= cnt_mem[cnt_raddr];
		cnt_rvld_q  <= cnt_vld_q[cnt_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
		end else if (cnt_we) begin
			cnt_vld_q[cnt_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (walk_we) begin
			walk_mem[walk_waddr] <= walk_wdata;
		end
		if (walk_re) begin
			walk_rdata_q <= walk_mem[walk_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ch_we) begin
			ch_mem[ch_waddr] <= ch_wdata;
		end
		if (ch_re) begin
			ch_rdata_q <= ch_mem[ch_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ld_idx_q    <= '0;
			next_q      <= '0;
			walk_n_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && req_acc && req.req_type == REQ_BUILD) begin
				ld_idx_q <= '0;
				next_q   <= ID_W'(SYMBOLS);
				walk_n_q <= ID_W'(NODES - 1);
			end
			if (state_q == ST_LOAD) begin
				ld_idx_q <= ld_idx_q + LDC_W'(1);
			end
			if (state_q == ST_MRG) begin
				next_q <= next_q + ID_W'(1);
			end
			if (state_q == ST_WR) begin
				walk_n_q <= walk_n_q - ID_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			byte_q    <= req.byte_value[SYM_AW-1:0];
			enc_sym_q <= enc_sym;
			enc_inr_q <= enc_inr;
		end
		if (out_load) begin
			out_sym_q  <= enc_sym_q;
			out_len_q  <= enc_inr_q ? rlen : '0;
			out_code_q <= enc_inr_q ? walk_rdata_q[CODE_W-1:0] : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.symbol      = out_sym_q;
	assign rsp.code_length = out_len_q;
	assign rsp.code_bits   = out_code_q;

	`HCBE_ASSERT_IMP(a_merge_pair, clk, arst_n, state_q == ST_MRG, links[0].node.vld && links[1].node.vld)
	`HCBE_ASSERT_IMP(a_head_sorted, clk, arst_n, links[0].node.vld && links[1].node.vld, links[0].node.weight <= links[1].node.weight)
	`HCBE_ASSERT_NXT(a_walk_done, clk, arst_n, state_q == ST_WR && walk_n_q == ID_W'(SYMBOLS), state_q == ST_IDLE)
endmodule

// ===== test/huffman_code_builder_encoder_core_check.sv =====
// checker for the huffman code builder and encoder: software tree build and code compare
`timescale 1ns / 1ps
module huffman_code_builder_encoder_core_check import hcbe_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	hcbe_in_if   req,
	hcbe_out_if  rsp,
	output int   fail_count,
	output int   pending
);
	typedef struct {
		logic [SYM_W-1:0]  sym;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] bits;
	} code_word_t;

	logic [31:0]       hist [256];
	logic [CODE_W-1:0] code_tab [256];
	logic [LEN_W-1:0]  len_tab [256];
	code_word_t        expected_codes [$];

	task automatic build_codes();
		logic [WEIGHT_W-1:0] wt [511];
		logic [17:0]         kids [255];
		int                  live_list [256];
		logic [CODE_W-1:0]   wc [511];
		logic [LEN_W-1:0]    wl [511];
		int live, best, pick, l, r, n;
		int picks [2];
		for (int i = 0; i < 256; i++) begin
			if (hist[i] == 0) hist[i] = 1;
			wt[i] = hist[i];
			live_list[i] = i;
		end
		live = 256;
		for (int nx = 256; nx < 511; nx++) begin
			for (int p = 0; p < 2; p++) begin
				best = 0;
				// node order equals node index, so tie goes to lower index
				for (int i = 1; i < live; i++) begin
					if (wt[live_list[i]] < wt[live_list[best]] ||
						(wt[live_list[i]] == wt[live_list[best]] &&
						live_list[i] < live_list[best]))
						best = i;
				end
				pick = live_list[best];
				live_list[best] = live_list[live-1];
				live--;
				picks[p] = pick;
			end
			wt[nx] = wt[picks[0]] + wt[picks[1]];
			kids[nx-256] = {picks[1][8:0], picks[0][8:0]};
			live_list[live] = nx;
			live++;
		end
		wc[510] = '0;
		wl[510] = '0;
		for (n = 510; n >= 256; n--) begin
			l = kids[n-256][8:0];
			r = kids[n-256][17:9];
			wc[l] = wc[n] << 1;
			wc[r] = (wc[n] << 1) | 1;
			wl[l] = (wl[n] < LEN_MAX) ? wl[n] + 1 : LEN_MAX;
			wl[r] = wl[l];
		end
		for (int i = 0; i < 256; i++) begin
			code_tab[i] = wc[i];
			len_tab[i] = wl[i];
		end
	endtask

	assign pending = expected_codes.size();

	always @(posedge clk or negedge arst_n) begin
		code_word_t e;
		logic [SYM_W-1:0] s;
		if (!arst_n) begin
			fail_count <= 0;
			expected_codes.delete();
			for (int i = 0; i < 256; i++) begin
				hist[i] = 0;
				code_tab[i] = '0;
				len_tab[i] = '0;
			end
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_codes.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected code word sym %0d", rsp.symbol);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_codes.pop_front();
					if (e.sym !== rsp.symbol || e.len !== rsp.code_length ||
						e.bits !== rsp.code_bits) begin
						if (fail_count < 10)
							$display("mismatch: exp sym %0d len %0d bits %h, got %0d %0d %h",
								e.sym, e.len, e.bits, rsp.symbol, rsp.code_length,
								rsp.code_bits);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (req.valid && req.ready) begin
				case (req.req_type)
					REQ_COUNT:
						if (hist[req.byte_value] != 32'hFFFF_FFFF)
							hist[req.byte_value] = hist[req.byte_value] + 1;
					REQ_BUILD: build_codes();
					default: begin
						s = (req.req_type == REQ_END) ? END_SYMBOL : req.byte_value;
						e.sym = s;
						e.len = len_tab[s];
						e.bits = code_tab[s];
						expected_codes.push_back(e);
					end
				endcase
			end
		end
	end
endmodule

// ===== test/huffman_code_builder_encoder_core_test.sv =====
// testbench top for the huffman code builder and encoder: stimulus and verdict
`timescale 1ns / 1ps
module huffman_code_builder_encoder_core_test import hcbe_pkg::*;;
	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending, cycles = 0;
	int   send_idle = 38, recv_idle = 52;
	hcbe_in_if  req();
	hcbe_out_if rsp();

	huffman_code_builder_encoder_core uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	huffman_code_builder_encoder_core_check chk (.clk(clk), .arst_n(arst_n), .req(req),
		.rsp(rsp), .fail_count(fail_count), .pending(pending));

	always #5 clk = ~clk;

	initial begin
		req.valid = 0;
		req.req_type = REQ_COUNT;
		req.byte_value = 0;
		rsp.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		rsp.ready <= ($urandom_range(99) >= recv_idle);
		if (cycles > 4000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// offers one word, holding it until accepted
	task automatic send_word(input logic [1:0] t, input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.req_type <= t;
		req.byte_value <= b;
		// ready only changes at clock edges, so a high level mid-cycle means the next edge takes it
		@(negedge clk);
		while (!req.ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		req.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_phase(input int n);
		int k;
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			// skewed bytes give deep trees
			b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
			if (k < 50) send_word(REQ_COUNT, b);
			else if (k < 53) send_word(REQ_BUILD, 8'($urandom));
			else if (k < 93) send_word(REQ_ENCODE, 8'($urandom));
			else send_word(REQ_END, 8'($urandom));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: build on empty histogram, extremes, end marker
		send_word(REQ_BUILD, 8'hFF);
		send_word(REQ_ENCODE, 8'h00);
		send_word(REQ_ENCODE, 8'hFF);
		send_word(REQ_END, 8'h00);
		for (int i = 0; i < 6; i++) send_word(REQ_COUNT, 8'hFF);
		send_word(REQ_COUNT, 8'h00);
		send_word(REQ_COUNT, 8'h55);
		send_word(REQ_COUNT, 8'hAA);
		send_word(REQ_BUILD, 8'h00);
		send_word(REQ_ENCODE, 8'hFF);
		send_word(REQ_ENCODE, 8'h00);
		send_word(REQ_ENCODE, 8'h55);
		send_word(REQ_ENCODE, 8'hAA);
		send_word(REQ_ENCODE, 8'h04);
		send_word(REQ_END, 8'hFF);
		drain();
		random_phase(170);
		drain();
		send_idle = 52;
		recv_idle = 38;
		random_phase(170);
		drain();
		send_idle = 0;
		recv_idle = 0;
		random_phase(160);
		send_word(REQ_BUILD, 8'h00);
		send_word(REQ_END, 8'h00);
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
